[design/haptic_pd_force_feedback_assert.svh]
// Assertion macros for the controller file (pdff_ctrl.sv).
// Both expect clk and rst_n in scope.
`ifndef HAPTIC_PD_FORCE_FEEDBACK_ASSERT_SVH
`define HAPTIC_PD_FORCE_FEEDBACK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pdff_pkg.sv]
package pdff_pkg;

    localparam int POS_BITS    = 24;
    localparam int ERR_BITS    = POS_BITS + 1;
    localparam int DERR_BITS   = POS_BITS + 2;
    localparam int GAIN_BITS   = 16;
    localparam int SMOOTH_BITS = 16;
    localparam int FORCE_BITS  = 32;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_BITS   = $clog2(NUM_AXES);

    // Shared multiply-accumulate unit widths.
    localparam int MAC_A_BITS  = (DERR_BITS > FORCE_BITS + 1) ? DERR_BITS : FORCE_BITS + 1;
    localparam int MAC_B_BITS  = SMOOTH_BITS + 1;
    localparam int MAC_P_BITS  = MAC_A_BITS + MAC_B_BITS + 1;
    localparam int ACC_BITS    = 66;

    // The PD sum is clamped to 46 bits and fed to the filter in two halves.
    localparam int PD_BITS     = 46;
    localparam int PD_LO_BITS  = 23;
    localparam int PD_HI_BITS  = PD_BITS - PD_LO_BITS;
    localparam int ROUND_SHIFT = 24;
    localparam int SHIFT_BYTE  = 8;

    localparam logic signed [FORCE_BITS-1:0] FORCE_MIN = {1'b1, {(FORCE_BITS-1){1'b0}}};
    localparam logic signed [FORCE_BITS-1:0] FORCE_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P_X = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D_X = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P_Y = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D_Y = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P_Z = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D_Z = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING = 3'd6;

    localparam logic [GAIN_BITS-1:0]   RESET_GAIN_P_X  = 16'd1600;
    localparam logic [GAIN_BITS-1:0]   RESET_GAIN_D_X  = 16'd4800;
    localparam logic [GAIN_BITS-1:0]   RESET_GAIN_P_Y  = 16'd1600;
    localparam logic [GAIN_BITS-1:0]   RESET_GAIN_D_Y  = 16'd4800;
    localparam logic [GAIN_BITS-1:0]   RESET_GAIN_P_Z  = 16'd2400;
    localparam logic [GAIN_BITS-1:0]   RESET_GAIN_D_Z  = 16'd9600;
    localparam logic [SMOOTH_BITS-1:0] RESET_SMOOTHING = 16'd52429;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [POS_BITS-1:0] stylus_x;
        logic signed [POS_BITS-1:0] stylus_y;
        logic signed [POS_BITS-1:0] stylus_z;
        logic signed [POS_BITS-1:0] target_x;
        logic signed [POS_BITS-1:0] target_y;
        logic signed [POS_BITS-1:0] target_z;
        logic                       grey_pressed;
        logic                       white_pressed;
    } item_t;

    typedef struct packed {
        logic signed [FORCE_BITS-1:0] force_x;
        logic signed [FORCE_BITS-1:0] force_y;
        logic signed [FORCE_BITS-1:0] force_z;
        logic                         autonomous;
        logic                         test_running;
    } result_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][GAIN_BITS-1:0] gain_p;
        logic [NUM_AXES-1:0][GAIN_BITS-1:0] gain_d;
        logic [SMOOTH_BITS-1:0]             smoothing;
    } cfg_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_BYTE,
        SH_PD_HI
    } mac_shift_t;

    typedef struct packed {
        logic       issue;
        logic       clear;
        mac_shift_t shift;
    } mac_cmd_t;

endpackage

[design/haptic_pd_force_feedback.sv]
// Channel   | Valid         | Stall         | Payload
// ----------+---------------+---------------+---------------------------------
// item      | item_valid    | item_stall    | item   (pdff_pkg::item_t)
// result    | result_valid  | result_stall  | result (pdff_pkg::result_t)
// config    | cfg_write     | none          | cfg_index, cfg_data
//
// A tick runs nine steps per axis on one multiply-accumulate unit, then commits its
// forces and loads its result; a button event goes straight to loading its result.
// The block takes the next item in the cycle after its result is loaded.
// Reset is asynchronous and active low; it loads the default gains and clears the controller state.
// A stalled result holds the block before loading the next one.
module haptic_pd_force_feedback (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  pdff_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output pdff_pkg::result_t                     result,
    input  logic                                  cfg_write,
    input  logic [pdff_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pdff_pkg::GAIN_BITS-1:0]        cfg_data
);
    import pdff_pkg::*;

    logic [GAIN_BITS-1:0]   gain_p_reg [NUM_AXES];
    logic [GAIN_BITS-1:0]   gain_d_reg [NUM_AXES];
    logic [SMOOTH_BITS-1:0] smoothing_reg;
    cfg_t                   cfg;

    mac_cmd_t                     mac_cmd;
    logic signed [MAC_A_BITS-1:0] mac_a;
    logic [MAC_B_BITS-1:0]        mac_b;
    logic signed [ACC_BITS-1:0]   mac_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg[0] <= RESET_GAIN_P_X;
            gain_d_reg[0] <= RESET_GAIN_D_X;
            gain_p_reg[1] <= RESET_GAIN_P_Y;
            gain_d_reg[1] <= RESET_GAIN_D_Y;
            gain_p_reg[2] <= RESET_GAIN_P_Z;
            gain_d_reg[2] <= RESET_GAIN_D_Z;
            smoothing_reg <= RESET_SMOOTHING;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P_X:  gain_p_reg[0] <= cfg_data;
                REG_GAIN_D_X:  gain_d_reg[0] <= cfg_data;
                REG_GAIN_P_Y:  gain_p_reg[1] <= cfg_data;
                REG_GAIN_D_Y:  gain_d_reg[1] <= cfg_data;
                REG_GAIN_P_Z:  gain_p_reg[2] <= cfg_data;
                REG_GAIN_D_Z:  gain_d_reg[2] <= cfg_data;
                REG_SMOOTHING: smoothing_reg <= SMOOTH_BITS'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            cfg.gain_p[i] = gain_p_reg[i];
            cfg.gain_d[i] = gain_d_reg[i];
        end
        cfg.smoothing = smoothing_reg;
    end

    pdff_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg          (cfg),
        .mac_cmd      (mac_cmd),
        .mac_a        (mac_a),
        .mac_b        (mac_b),
        .mac_acc      (mac_acc)
    );

    pdff_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

endmodule

[design/pdff_mac.sv]
module pdff_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pdff_pkg::mac_cmd_t                     cmd,
    input  logic signed [pdff_pkg::MAC_A_BITS-1:0] a,
    input  logic        [pdff_pkg::MAC_B_BITS-1:0] b,
    output logic signed [pdff_pkg::ACC_BITS-1:0]   acc
);
    import pdff_pkg::*;

    logic signed [MAC_P_BITS-1:0] prod_reg;
    logic                         prod_valid_reg;
    logic                         prod_clear_reg;
    mac_shift_t                   prod_shift_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   acc_next;
    logic signed [ACC_BITS-1:0]   prod_ext;
    logic signed [ACC_BITS-1:0]   addend;

    // Stage one: the multiply. The b operand is unsigned.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_clear_reg <= 1'b0;
            prod_shift_reg <= SH_NONE;
        end
        else
        begin
            prod_valid_reg <= cmd.issue;
            prod_clear_reg <= cmd.clear;
            prod_shift_reg <= cmd.shift;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * $signed({1'b0, b});
        acc_reg  <= acc_next;
    end

    // Stage two: align and accumulate.
    always_comb
    begin
        prod_ext = {{(ACC_BITS-MAC_P_BITS){prod_reg[MAC_P_BITS-1]}}, prod_reg};
        case (prod_shift_reg)
            SH_NONE:  addend = prod_ext;
            SH_BYTE:  addend = prod_ext <<< SHIFT_BYTE;
            SH_PD_HI: addend = prod_ext <<< PD_LO_BITS;
            default:  addend = prod_ext;
        endcase
        acc_next = acc_reg;
        if (prod_valid_reg)
        begin
            acc_next = (prod_clear_reg ? '0 : acc_reg) + addend;
        end
    end

    assign acc = acc_reg;

endmodule

[design/pdff_ctrl.sv]
`include "haptic_pd_force_feedback_assert.svh"

module pdff_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  pdff_pkg::item_t                        item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output pdff_pkg::result_t                      result,
    input  pdff_pkg::cfg_t                         cfg,
    output pdff_pkg::mac_cmd_t                     mac_cmd,
    output logic signed [pdff_pkg::MAC_A_BITS-1:0] mac_a,
    output logic        [pdff_pkg::MAC_B_BITS-1:0] mac_b,
    input  logic signed [pdff_pkg::ACC_BITS-1:0]   mac_acc
);
    import pdff_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PD_P,
        S_PD_D,
        S_PD_WAIT,
        S_CLAMP,
        S_LP_NEW,
        S_LP_HI,
        S_LP_OLD,
        S_LP_WAIT,
        S_ROUND,
        S_COMMIT,
        S_DONE
    } state_t;

    localparam logic [AXIS_BITS-1:0] AXIS_LAST = AXIS_BITS'(NUM_AXES - 1);
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (ROUND_SHIFT - 1);
    localparam logic [MAC_B_BITS-1:0] WEIGHT_ONE = MAC_B_BITS'(2**SMOOTH_BITS);
    localparam logic signed [PD_BITS-1:0] PD_MIN = {1'b1, {(PD_BITS-1){1'b0}}};
    localparam logic signed [PD_BITS-1:0] PD_MAX = {1'b0, {(PD_BITS-1){1'b1}}};

    state_t                       state_reg;
    logic [AXIS_BITS-1:0]         axis_reg;
    logic signed [ERR_BITS-1:0]   err_reg [NUM_AXES];
    logic signed [ERR_BITS-1:0]   last_error_reg [NUM_AXES];
    logic signed [FORCE_BITS-1:0] last_force_reg [NUM_AXES];
    logic signed [FORCE_BITS-1:0] force_new_reg [NUM_AXES];
    logic signed [PD_BITS-1:0]    pd_reg;
    logic                         auto_reg;
    logic                         ref_changed_reg;
    logic                         test_reg;
    logic                         last_grey_reg;
    logic                         last_white_reg;
    logic                         result_valid_reg;
    result_t                      result_reg;

    logic signed [ERR_BITS-1:0]   err_cur;
    logic signed [DERR_BITS-1:0]  derr_cur;
    logic [MAC_B_BITS-1:0]        weight_new;
    logic signed [PD_BITS-1:0]    pd_next;
    logic signed [FORCE_BITS-1:0] force_round;
    logic                         accept;
    logic                         out_free;

    function automatic logic signed [FORCE_BITS-1:0] sat_quot(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-ROUND_SHIFT-FORCE_BITS:0] upper;
        upper = v[ACC_BITS-1:ROUND_SHIFT+FORCE_BITS-1];
        if ((&upper) || (~|upper))
            return v[ROUND_SHIFT+FORCE_BITS-1:ROUND_SHIFT];
        else if (v[ACC_BITS-1])
            return FORCE_MIN;
        else
            return FORCE_MAX;
    endfunction

    function automatic logic signed [FORCE_BITS-1:0] sat_sum(
        input logic signed [FORCE_BITS-1:0] x,
        input logic signed [FORCE_BITS-1:0] y
    );
        logic signed [FORCE_BITS:0] s;
        s = (FORCE_BITS+1)'(x) + (FORCE_BITS+1)'(y);
        if (s[FORCE_BITS] == s[FORCE_BITS-1])
            return s[FORCE_BITS-1:0];
        else if (s[FORCE_BITS])
            return FORCE_MIN;
        else
            return FORCE_MAX;
    endfunction

    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        err_cur    = err_reg[axis_reg];
        derr_cur   = DERR_BITS'(err_cur) - DERR_BITS'(last_error_reg[axis_reg]);
        weight_new = WEIGHT_ONE - MAC_B_BITS'(cfg.smoothing);

        // Clamp the PD sum to the filter's input range.
        if ((&mac_acc[ACC_BITS-1:PD_BITS-1]) || (~|mac_acc[ACC_BITS-1:PD_BITS-1]))
            pd_next = mac_acc[PD_BITS-1:0];
        else if (mac_acc[ACC_BITS-1])
            pd_next = PD_MIN;
        else
            pd_next = PD_MAX;

        // Round half up to Q15.16; x and y stay at zero in manual mode.
        force_round = sat_quot(mac_acc + ROUND_HALF);
        if ((axis_reg != AXIS_LAST) && !auto_reg)
            force_round = '0;

        mac_cmd.issue = 1'b0;
        mac_cmd.clear = 1'b0;
        mac_cmd.shift = SH_NONE;
        mac_a         = '0;
        mac_b         = '0;
        case (state_reg)
            S_PD_P:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_a         = MAC_A_BITS'(err_cur);
                mac_b         = MAC_B_BITS'(cfg.gain_p[axis_reg]);
            end
            S_PD_D:
            begin
                mac_cmd.issue = 1'b1;
                mac_a         = MAC_A_BITS'(derr_cur);
                mac_b         = MAC_B_BITS'(cfg.gain_d[axis_reg]);
            end
            S_LP_NEW:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_a         = MAC_A_BITS'($signed({1'b0, pd_reg[PD_LO_BITS-1:0]}));
                mac_b         = weight_new;
            end
            S_LP_HI:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.shift = SH_PD_HI;
                mac_a         = MAC_A_BITS'($signed(pd_reg[PD_BITS-1:PD_LO_BITS]));
                mac_b         = weight_new;
            end
            S_LP_OLD:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.shift = SH_BYTE;
                mac_a         = MAC_A_BITS'(last_force_reg[axis_reg]);
                mac_b         = MAC_B_BITS'(cfg.smoothing);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= '0;
            pd_reg           <= '0;
            auto_reg         <= 1'b0;
            ref_changed_reg  <= 1'b0;
            test_reg         <= 1'b0;
            last_grey_reg    <= 1'b0;
            last_white_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                err_reg[i]        <= '0;
                last_error_reg[i] <= '0;
                last_force_reg[i] <= '0;
                force_new_reg[i]  <= '0;
            end
        end
        else
        begin
            // In S_DONE the output register is reloaded instead.
            if (result_valid_reg && !result_stall && (state_reg != S_DONE))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        axis_reg <= '0;
                        if (item.operation == OP_BUTTON)
                        begin
                            if (item.grey_pressed && !last_grey_reg)
                            begin
                                ref_changed_reg <= 1'b1;
                                auto_reg        <= !auto_reg;
                            end
                            if (item.white_pressed && !last_white_reg)
                                test_reg <= !test_reg;
                            last_grey_reg  <= item.grey_pressed;
                            last_white_reg <= item.white_pressed;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            err_reg[0] <= ERR_BITS'(item.target_x) - ERR_BITS'(item.stylus_x);
                            err_reg[1] <= ERR_BITS'(item.target_y) - ERR_BITS'(item.stylus_y);
                            err_reg[2] <= ERR_BITS'(item.target_z) - ERR_BITS'(item.stylus_z);
                            state_reg  <= S_PD_P;
                        end
                    end
                end
                S_PD_P:    state_reg <= S_PD_D;
                S_PD_D:    state_reg <= S_PD_WAIT;
                S_PD_WAIT: state_reg <= S_CLAMP;
                S_CLAMP:
                begin
                    pd_reg    <= pd_next;
                    state_reg <= S_LP_NEW;
                end
                S_LP_NEW:  state_reg <= S_LP_HI;
                S_LP_HI:   state_reg <= S_LP_OLD;
                S_LP_OLD:  state_reg <= S_LP_WAIT;
                S_LP_WAIT: state_reg <= S_ROUND;
                S_ROUND:
                begin
                    force_new_reg[axis_reg] <= force_round;
                    if (axis_reg == AXIS_LAST)
                        state_reg <= S_COMMIT;
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_PD_P;
                    end
                end
                S_COMMIT:
                begin
                    // After a reference change the old force is carried over once.
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        last_error_reg[i] <= err_reg[i];
                        if (ref_changed_reg)
                            last_force_reg[i] <= sat_sum(force_new_reg[i], last_force_reg[i]);
                        else
                            last_force_reg[i] <= force_new_reg[i];
                    end
                    ref_changed_reg <= 1'b0;
                    state_reg       <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        result_reg.force_x      <= last_force_reg[0];
                        result_reg.force_y      <= last_force_reg[1];
                        result_reg.force_z      <= last_force_reg[2];
                        result_reg.autonomous   <= auto_reg;
                        result_reg.test_running <= test_reg;
                        result_valid_reg        <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PDFF_ASSERT_NOW(a_axis_range, state_reg != S_IDLE, axis_reg <= AXIS_LAST, "axis out of range")
    `PDFF_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != S_IDLE, "accepted item not held")
    `PDFF_ASSERT_NEXT(a_ref_cleared, state_reg == S_COMMIT, !ref_changed_reg, "reference flag kept")
    `PDFF_ASSERT_NOW(a_result_source, $rose(result_valid_reg), $past(state_reg) == S_DONE, "stray result")

endmodule

[tb/haptic_pd_force_feedback_test.sv]
`timescale 1ns / 100ps

module haptic_pd_force_feedback_test;

    import pdff_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT = 12;
    localparam int AXIS_Z = 2;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS = 250;

    localparam longint PD_MAX = (longint'(1) <<< (PD_BITS - 1)) - 1;
    localparam longint SMOOTH_ONE = longint'(1) <<< SMOOTH_BITS;
    localparam longint ROUND_HALF = longint'(1) <<< (ROUND_SHIFT - 1);

    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};

    localparam logic [CFG_INDEX_BITS-1:0] P_GAIN_REG [NUM_AXES] =
        '{REG_GAIN_P_X, REG_GAIN_P_Y, REG_GAIN_P_Z};
    localparam logic [CFG_INDEX_BITS-1:0] D_GAIN_REG [NUM_AXES] =
        '{REG_GAIN_D_X, REG_GAIN_D_Y, REG_GAIN_D_Z};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [GAIN_BITS-1:0] cfg_data = '0;

    // Controller state as the block should hold it.
    logic [GAIN_BITS-1:0] cfg_shadow [7];
    logic [GAIN_BITS-1:0] cfg_plan [7];
    longint prev_err [NUM_AXES];
    logic signed [FORCE_BITS-1:0] prev_force [NUM_AXES];
    logic auto_on;
    logic ref_changed;
    logic test_on;
    logic grey_was;
    logic white_was;

    result_t force_cmd_q [$];
    int errors = 0;
    int idle_cycles = 0;
    logic rush = 1'b0;

    haptic_pd_force_feedback u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [GAIN_BITS-1:0] reset_value(input int r);
        case (r)
            REG_GAIN_P_X: return RESET_GAIN_P_X;
            REG_GAIN_D_X: return RESET_GAIN_D_X;
            REG_GAIN_P_Y: return RESET_GAIN_P_Y;
            REG_GAIN_D_Y: return RESET_GAIN_D_Y;
            REG_GAIN_P_Z: return RESET_GAIN_P_Z;
            REG_GAIN_D_Z: return RESET_GAIN_D_Z;
            default:      return RESET_SMOOTHING;
        endcase
    endfunction

    function automatic void reset_controller();
        for (int r = REG_GAIN_P_X; r <= REG_SMOOTHING; r++) begin
            cfg_shadow[r] = reset_value(r);
            cfg_plan[r] = reset_value(r);
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            prev_err[k] = 0;
            prev_force[k] = '0;
        end
        auto_on = 1'b0;
        ref_changed = 1'b0;
        test_on = 1'b0;
        grey_was = 1'b0;
        white_was = 1'b0;
    endfunction

    function automatic logic signed [FORCE_BITS-1:0] clip_force(input longint v);
        if (v > longint'(FORCE_MAX))
            return FORCE_MAX;
        else if (v < longint'(FORCE_MIN))
            return FORCE_MIN;
        return v[FORCE_BITS-1:0];
    endfunction

    // PD term followed by the one-pole filter, rounded half up to Q15.16.
    function automatic logic signed [FORCE_BITS-1:0] axis_force(
        input longint err,
        input longint derr,
        input logic [GAIN_BITS-1:0] kp,
        input logic [GAIN_BITS-1:0] kd,
        input logic [SMOOTH_BITS-1:0] s,
        input logic signed [FORCE_BITS-1:0] prev
    );
        longint kpl;
        longint kdl;
        longint sl;
        longint pl;
        longint pd;
        longint acc;
        kpl = kp;
        kdl = kd;
        sl = s;
        pl = prev;
        pd = kpl * err + kdl * derr;
        if (pd > PD_MAX)
            pd = PD_MAX;
        else if (pd < -PD_MAX - 1)
            pd = -PD_MAX - 1;
        acc = pd * (SMOOTH_ONE - sl) + pl * sl * (longint'(1) <<< SHIFT_BYTE);
        return clip_force((acc + ROUND_HALF) >>> ROUND_SHIFT);
    endfunction

    function automatic result_t controller_step(input item_t it);
        logic signed [POS_BITS-1:0] pos [NUM_AXES];
        logic signed [POS_BITS-1:0] tgt [NUM_AXES];
        logic signed [FORCE_BITS-1:0] frc [NUM_AXES];
        longint err;
        result_t res;
        pos[0] = it.stylus_x;
        pos[1] = it.stylus_y;
        pos[2] = it.stylus_z;
        tgt[0] = it.target_x;
        tgt[1] = it.target_y;
        tgt[2] = it.target_z;
        if (it.operation == OP_BUTTON) begin
            if (it.grey_pressed && !grey_was) begin
                ref_changed = 1'b1;
                auto_on = !auto_on;
            end
            if (it.white_pressed && !white_was)
                test_on = !test_on;
            grey_was = it.grey_pressed;
            white_was = it.white_pressed;
        end
        else begin
            for (int k = 0; k < NUM_AXES; k++) begin
                err = longint'(tgt[k]) - longint'(pos[k]);
                // Only Z is controlled in manual mode, but every error is kept.
                if (k != AXIS_Z && !auto_on)
                    frc[k] = '0;
                else
                    frc[k] = axis_force(err, err - prev_err[k],
                                        cfg_shadow[P_GAIN_REG[k]], cfg_shadow[D_GAIN_REG[k]],
                                        cfg_shadow[REG_SMOOTHING], prev_force[k]);
                prev_err[k] = err;
            end
            if (ref_changed) begin
                ref_changed = 1'b0;
                for (int k = 0; k < NUM_AXES; k++)
                    frc[k] = clip_force(longint'(frc[k]) + longint'(prev_force[k]));
            end
            for (int k = 0; k < NUM_AXES; k++)
                prev_force[k] = frc[k];
        end
        res.force_x = prev_force[0];
        res.force_y = prev_force[1];
        res.force_z = prev_force[2];
        res.autonomous = auto_on;
        res.test_running = test_on;
        return res;
    endfunction

    function automatic int pick_wait();
        if (rush || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic signed [POS_BITS-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return '0;
            3:       return POS_BITS'($urandom_range(0, 4000)) - POS_BITS'(2000);
            default: return POS_BITS'($urandom);
        endcase
    endfunction

    function automatic item_t make_tick(
        input logic signed [POS_BITS-1:0] sx, input logic signed [POS_BITS-1:0] sy,
        input logic signed [POS_BITS-1:0] sz, input logic signed [POS_BITS-1:0] tx,
        input logic signed [POS_BITS-1:0] ty, input logic signed [POS_BITS-1:0] tz
    );
        item_t it;
        it.operation = OP_TICK;
        it.stylus_x = sx;
        it.stylus_y = sy;
        it.stylus_z = sz;
        it.target_x = tx;
        it.target_y = ty;
        it.target_z = tz;
        it.grey_pressed = 1'($urandom);
        it.white_pressed = 1'($urandom);
        return it;
    endfunction

    function automatic item_t make_button(input logic grey, input logic white);
        item_t it;
        it.operation = OP_BUTTON;
        it.stylus_x = POS_BITS'($urandom);
        it.stylus_y = POS_BITS'($urandom);
        it.stylus_z = POS_BITS'($urandom);
        it.target_x = POS_BITS'($urandom);
        it.target_y = POS_BITS'($urandom);
        it.target_z = POS_BITS'($urandom);
        it.grey_pressed = grey;
        it.white_pressed = white;
        return it;
    endfunction

    // About half of the targets sit close to the stylus, as they would in a tracking loop.
    function automatic item_t rand_tick();
        logic signed [POS_BITS-1:0] s [NUM_AXES];
        logic signed [POS_BITS-1:0] t [NUM_AXES];
        for (int k = 0; k < NUM_AXES; k++) begin
            s[k] = rand_pos();
            if ($urandom_range(0, 1) == 0)
                t[k] = s[k] + POS_BITS'($urandom_range(0, 2000)) - POS_BITS'(1000);
            else
                t[k] = rand_pos();
        end
        return make_tick(s[0], s[1], s[2], t[0], t[1], t[2]);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        force_cmd_q.insert(force_cmd_q.size(), controller_step(it));
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (force_cmd_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config();
        wait_idle();
        for (int r = REG_GAIN_P_X; r <= REG_SMOOTHING; r++) begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(r);
            cfg_data <= cfg_plan[r];
            @(posedge clk);
            cfg_shadow[r] = cfg_plan[r];
        end
        cfg_write <= 1'b0;
    endtask

    task automatic set_all_gains(input logic [GAIN_BITS-1:0] g,
                                 input logic [SMOOTH_BITS-1:0] s);
        for (int k = 0; k < NUM_AXES; k++) begin
            cfg_plan[P_GAIN_REG[k]] = g;
            cfg_plan[D_GAIN_REG[k]] = g;
        end
        cfg_plan[REG_SMOOTHING] = s;
        load_config();
    endtask

    // Default gains: zero and full-scale errors, both buttons, mode changes.
    task automatic test_default_gains();
        send_item(make_tick('0, '0, '0, '0, '0, '0));
        send_item(make_tick(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        send_item(make_tick(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
        send_item(make_button(1'b1, 1'b1));
        send_item(rand_tick());
        send_item(rand_tick());
        send_item(make_button(1'b1, 1'b0));
        send_item(make_button(1'b0, 1'b0));
        send_item(make_button(1'b1, 1'b0));
        send_item(rand_tick());
        send_item(make_button(1'b0, 1'b1));
    endtask

    // Full gains with no smoothing drive the forces into saturation, and the
    // addition after a mode change saturates as well.
    task automatic test_extreme_gains();
        set_all_gains('1, '0);
        send_item(make_button(1'b1, 1'b0));
        send_item(make_tick(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        send_item(make_tick(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        send_item(make_tick(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
        send_item(make_button(1'b0, 1'b0));
        send_item(make_button(1'b1, 1'b0));
        send_item(make_tick(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
    endtask

    task automatic test_smoothing_extremes();
        set_all_gains('0, '1);
        send_item(rand_tick());
        send_item(rand_tick());
        set_all_gains('1, '1);
        send_item(make_tick(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        send_item(rand_tick());
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int r = REG_GAIN_P_X; r <= REG_SMOOTHING; r++) begin
                case ($urandom_range(0, 4))
                    0:       cfg_plan[r] = '0;
                    1:       cfg_plan[r] = '1;
                    2:       cfg_plan[r] = reset_value(r);
                    default: cfg_plan[r] = GAIN_BITS'($urandom);
                endcase
            end
            if (phase == 0)
                for (int r = REG_GAIN_P_X; r <= REG_SMOOTHING; r++)
                    cfg_plan[r] = reset_value(r);
            load_config();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    rush = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                if ($urandom_range(0, 3) == 0)
                    send_item(make_button(1'($urandom), 1'($urandom)));
                else
                    send_item(rand_tick());
            end
        end
        rush = 1'b0;
    endtask

    // Receiver: ahead of each result it holds result_stall high for a random wait, which may be zero.
    initial begin : result_sink
        int n;
        forever begin
            n = pick_wait();
            if (n > 0) begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (force_cmd_q.size() == 0) begin
                $error("result arrived with no item outstanding");
                errors++;
            end
            else begin
                want = force_cmd_q.pop_front();
                if (result.force_x !== want.force_x) begin
                    $error("force_x: expected %0d, got %0d", want.force_x, result.force_x);
                    errors++;
                end
                if (result.force_y !== want.force_y) begin
                    $error("force_y: expected %0d, got %0d", want.force_y, result.force_y);
                    errors++;
                end
                if (result.force_z !== want.force_z) begin
                    $error("force_z: expected %0d, got %0d", want.force_z, result.force_z);
                    errors++;
                end
                if (result.autonomous !== want.autonomous) begin
                    $error("autonomous: expected %0b, got %0b",
                           want.autonomous, result.autonomous);
                    errors++;
                end
                if (result.test_running !== want.test_running) begin
                    $error("test_running: expected %0b, got %0b",
                           want.test_running, result.test_running);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        reset_controller();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_default_gains();
        test_extreme_gains();
        test_smoothing_extremes();
        test_random_traffic();
        wait_idle();
        if (errors == 0 && force_cmd_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
